// File: hw/rtl/bcta_pkg.sv
`default_nettype none

package bcta_pkg;

   localparam int BCTA_BLOCKS_DEF   = 1024;
   localparam int BCTA_RESERVED_DEF = 1;

   // Marker offsets above the block count
   localparam int MARK_FREE  = 0;
   localparam int MARK_END   = 1;
   localparam int MARK_RESV  = 2;
   localparam int MARK_INVAL = 3;
   localparam int MARK_DIR   = 4;
   localparam int MARK_NONE  = 5;

   // Operation kinds
   localparam logic [2:0] KIND_INIT        = 3'd0;
   localparam logic [2:0] KIND_ALLOC_FIRST = 3'd1;
   localparam logic [2:0] KIND_ALLOC_NEAR  = 3'd2;
   localparam logic [2:0] KIND_FREE        = 3'd3;
   localparam logic [2:0] KIND_LINK        = 3'd4;
   localparam logic [2:0] KIND_GET_NEXT    = 3'd5;

   // Status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NOFREE  = 3'd1;
   localparam logic [2:0] ST_RANGE   = 3'd2;
   localparam logic [2:0] ST_CORRUPT = 3'd3;
   localparam logic [2:0] ST_DIR     = 3'd4;
   localparam logic [2:0] ST_RESV    = 3'd5;
   localparam logic [2:0] ST_ALREADY = 3'd6;

   typedef struct packed {
      logic start;
      logic up_only;
      logic advance;
   } bcta_scan_ctl_type;

endpackage

`default_nettype wire

// File: hw/rtl/bcta_ram.sv
`default_nettype none

module bcta_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/bcta_scan.sv
`default_nettype none

module bcta_scan #(
   parameter int BLOCKS = bcta_pkg::BCTA_BLOCKS_DEF,
   localparam int IW = $clog2(BLOCKS),
   localparam int CW = IW + 2
) (
   input  wire logic                        clock,
   input  wire bcta_pkg::bcta_scan_ctl_type scan_ctl,
   input  wire logic [CW-1:0]               scan_hint,
   output logic                             scan_emit,
   output logic [IW-1:0]                    scan_addr
);

   import bcta_pkg::*;

   localparam logic [CW-1:0] LIMIT = CW'(BLOCKS);

   // side_ff low: lower neighbor at this offset comes next
   logic [CW-1:0] off_ff, off_in;
   logic          side_ff, side_in;
   logic [CW-1:0] hint_ff;
   logic          up_ff;

   logic [CW-1:0] off1;
   logic          low_ok, low_ok1, high_ok;

   always_comb begin
      off1    = off_ff + CW'(1);
      low_ok  = !up_ff && (off_ff <= hint_ff);
      low_ok1 = !up_ff && (off1 <= hint_ff);
      high_ok = (hint_ff + off_ff) < LIMIT;
      scan_emit = 1'b0;
      scan_addr = IW'(hint_ff);
      off_in    = off_ff;
      side_in   = side_ff;
      if (!side_ff) begin
         if (low_ok) begin
            scan_emit = 1'b1;
            scan_addr = IW'(hint_ff - off_ff);
            side_in   = 1'b1;
         end else if (high_ok) begin
            scan_emit = 1'b1;
            scan_addr = IW'(hint_ff + off_ff);
            off_in    = off1;
         end
      end else begin
         if (high_ok) begin
            scan_emit = 1'b1;
            scan_addr = IW'(hint_ff + off_ff);
            off_in    = off1;
            side_in   = 1'b0;
         end else if (low_ok1) begin
            // upper side exhausted: walk down only
            scan_emit = 1'b1;
            scan_addr = IW'(hint_ff - off1);
            off_in    = off1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (scan_ctl.start) begin
         off_ff  <= '0;
         side_ff <= 1'b1;
         hint_ff <= scan_hint;
         up_ff   <= scan_ctl.up_only;
      end else if (scan_ctl.advance) begin
         off_ff  <= off_in;
         side_ff <= side_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/bcta_ctrl.sv
`default_nettype none

module bcta_ctrl #(
   parameter int BLOCKS   = bcta_pkg::BCTA_BLOCKS_DEF,
   parameter int RESERVED = bcta_pkg::BCTA_RESERVED_DEF,
   localparam int IW = $clog2(BLOCKS),
   localparam int CW = IW + 2,
   localparam int EW = $clog2(BLOCKS + 6)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [23:0]                 req_tdata,
   input  wire logic [2:0]                  req_tuser,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [15:0]                      rsp_tdata,
   output logic                             rsp_tuser,
   output logic                             ram_we,
   output logic [IW-1:0]                    ram_waddr,
   output logic [EW-1:0]                    ram_wdata,
   output logic [IW-1:0]                    ram_raddr,
   input  wire logic [EW-1:0]               ram_rdata,
   output bcta_pkg::bcta_scan_ctl_type      scan_ctl,
   output logic [CW-1:0]                    scan_hint,
   input  wire logic                        scan_emit,
   input  wire logic [IW-1:0]               scan_addr
);

   import bcta_pkg::*;

   localparam logic [EW-1:0] M_FREE  = EW'(BLOCKS + MARK_FREE);
   localparam logic [EW-1:0] M_END   = EW'(BLOCKS + MARK_END);
   localparam logic [EW-1:0] M_RESV  = EW'(BLOCKS + MARK_RESV);
   localparam logic [EW-1:0] M_INVAL = EW'(BLOCKS + MARK_INVAL);
   localparam logic [EW-1:0] M_DIR   = EW'(BLOCKS + MARK_DIR);
   localparam logic [10:0]   NONE_OUT = 11'(BLOCKS + MARK_NONE);
   localparam logic [IW-1:0] LAST_IDX = IW'(BLOCKS - 1);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_START = 3'd2;
   localparam logic [2:0] S_RD_A  = 3'd3;
   localparam logic [2:0] S_RD_B  = 3'd4;
   localparam logic [2:0] S_LINK2 = 3'd5;
   localparam logic [2:0] S_SCAN  = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0]    state_ff, state_in;
   logic [IW-1:0] clr_ptr_ff, clr_ptr_in;
   logic          clr_init_ff, clr_init_in;
   logic          pend_ff, pend_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [2:0]    kind_ff, kind_in;
   logic [10:0]   blk_ff, blk_in;
   logic [10:0]   oth_ff, oth_in;
   logic [IW-1:0] pend_addr_ff, pend_addr_in;
   logic [EW-1:0] ea_ff, ea_in;
   logic [2:0]    res_st_ff, res_st_in;
   logic [10:0]   res_blk_ff, res_blk_in;
   logic          res_end_ff, res_end_in;
   logic [2:0]    rsp_st_ff, rsp_st_in;
   logic [10:0]   rsp_blk_ff, rsp_blk_in;
   logic          rsp_end_ff, rsp_end_in;

   logic blk_rng, oth_rng, found;
   logic ea_bad, eb_bad;

   always_comb begin
      state_in     = state_ff;
      clr_ptr_in   = clr_ptr_ff;
      clr_init_in  = clr_init_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      blk_in       = blk_ff;
      oth_in       = oth_ff;
      pend_addr_in = pend_addr_ff;
      ea_in        = ea_ff;
      res_st_in    = res_st_ff;
      res_blk_in   = res_blk_ff;
      res_end_in   = res_end_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_blk_in   = rsp_blk_ff;
      rsp_end_in   = rsp_end_ff;

      ram_we    = 1'b0;
      ram_waddr = IW'(blk_ff);
      ram_wdata = M_FREE;
      ram_raddr = IW'(blk_ff);
      scan_ctl  = '0;
      scan_hint = CW'(blk_ff);

      blk_rng = 32'(blk_ff) >= 32'(BLOCKS);
      oth_rng = 32'(oth_ff) >= 32'(BLOCKS);
      found   = pend_ff && (ram_rdata == M_FREE);
      ea_bad  = (ea_ff == M_RESV) || (ea_ff == M_INVAL);
      eb_bad  = (ram_rdata == M_RESV) || (ram_rdata == M_INVAL);

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ptr_ff;
            ram_wdata = (32'(clr_ptr_ff) < 32'(RESERVED)) ? M_RESV : M_FREE;
            if (clr_ptr_ff == LAST_IDX) begin
               clr_ptr_in = '0;
               if (clr_init_ff) begin
                  res_st_in = ST_OK;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               clr_ptr_in = clr_ptr_ff + IW'(1);
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in  = req_tuser;
               blk_in   = req_tdata[10:0];
               oth_in   = req_tdata[21:11];
               state_in = S_START;
            end
         end
         S_START: begin
            pend_in    = 1'b0;
            res_st_in  = ST_RANGE;
            res_blk_in = NONE_OUT;
            res_end_in = 1'b0;
            state_in   = S_DONE;
            case (kind_ff)
               KIND_INIT: begin
                  clr_init_in = 1'b1;
                  clr_ptr_in  = '0;
                  state_in    = S_CLEAR;
               end
               KIND_ALLOC_FIRST: begin
                  scan_ctl.start   = 1'b1;
                  scan_ctl.up_only = 1'b1;
                  scan_hint        = CW'(RESERVED);
                  state_in         = S_SCAN;
               end
               KIND_ALLOC_NEAR: begin
                  if (!blk_rng) begin
                     scan_ctl.start = 1'b1;
                     state_in       = S_SCAN;
                  end
               end
               KIND_FREE, KIND_GET_NEXT: begin
                  if (!blk_rng) begin
                     state_in = S_RD_A;
                  end
               end
               KIND_LINK: begin
                  if (!blk_rng && !oth_rng) begin
                     state_in = S_RD_A;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_RD_A: begin
            state_in = S_DONE;
            case (kind_ff)
               KIND_FREE: begin
                  if (eb_bad) begin
                     res_st_in = ST_RESV;
                  end else if (ram_rdata == M_FREE) begin
                     res_st_in = ST_ALREADY;
                  end else begin
                     ram_we    = 1'b1;
                     ram_wdata = M_FREE;
                     res_st_in = ST_OK;
                  end
               end
               KIND_GET_NEXT: begin
                  res_blk_in = 11'(ram_rdata);
                  if (ram_rdata == M_END) begin
                     res_st_in  = ST_OK;
                     res_end_in = 1'b1;
                  end else if (ram_rdata == M_FREE || ram_rdata == M_INVAL) begin
                     res_st_in = ST_CORRUPT;
                  end else if (ram_rdata == M_DIR) begin
                     res_st_in = ST_DIR;
                  end else if (32'(ram_rdata) < 32'(BLOCKS)) begin
                     res_st_in = ST_OK;
                  end else begin
                     res_st_in = ST_CORRUPT;
                  end
               end
               default: begin
                  // link: hold the source entry, fetch the destination
                  ea_in     = ram_rdata;
                  ram_raddr = IW'(oth_ff);
                  state_in  = S_RD_B;
               end
            endcase
         end
         S_RD_B: begin
            state_in = S_DONE;
            if (ea_bad || eb_bad) begin
               res_st_in = ST_RESV;
            end else if (ea_ff == M_DIR || ram_rdata == M_DIR) begin
               res_st_in = ST_DIR;
            end else begin
               ram_we    = 1'b1;
               ram_wdata = EW'(oth_ff);
               res_st_in = ST_OK;
               if (ram_rdata == M_FREE && blk_ff != oth_ff) begin
                  state_in = S_LINK2;
               end
            end
         end
         S_LINK2: begin
            ram_we    = 1'b1;
            ram_waddr = IW'(oth_ff);
            ram_wdata = M_END;
            state_in  = S_DONE;
         end
         S_SCAN: begin
            if (found) begin
               ram_we     = 1'b1;
               ram_waddr  = pend_addr_ff;
               ram_wdata  = M_END;
               res_st_in  = ST_OK;
               res_blk_in = 11'(pend_addr_ff);
               state_in   = S_DONE;
            end else if (scan_emit) begin
               ram_raddr        = scan_addr;
               pend_in          = 1'b1;
               pend_addr_in     = scan_addr;
               scan_ctl.advance = 1'b1;
            end else begin
               res_st_in = ST_NOFREE;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_st_in    = res_st_ff;
               rsp_blk_in   = res_blk_ff;
               rsp_end_in   = res_end_ff;
               clr_init_in  = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ptr_ff   <= '0;
         clr_init_ff  <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ptr_ff   <= clr_ptr_in;
         clr_init_ff  <= clr_init_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      blk_ff       <= blk_in;
      oth_ff       <= oth_in;
      pend_addr_ff <= pend_addr_in;
      ea_ff        <= ea_in;
      res_st_ff    <= res_st_in;
      res_blk_ff   <= res_blk_in;
      res_end_ff   <= res_end_in;
      rsp_st_ff    <= rsp_st_in;
      rsp_blk_ff   <= rsp_blk_in;
      rsp_end_ff   <= rsp_end_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_blk_ff, rsp_st_ff};
   assign rsp_tuser  = rsp_end_ff;

endmodule

`default_nettype wire

// File: hw/rtl/block_chain_table_allocator_top.sv
// Sequence: after accept, S_START checks the request, then S_RD_A (and S_RD_B, S_LINK2 for link),
// S_SCAN for allocate or S_CLEAR for init runs, and S_DONE moves the result into the output register.
// Throughput: one transaction in flight; allocation walks the table one entry per cycle
// through the single read port of the table memory.
// Reset: synchronous, active high; a clearing pass rewrites every entry of the table
// (first RESERVED entries reserved, rest free) before the first transaction is taken.
`default_nettype none

module block_chain_table_allocator_top #(
   parameter int BLOCKS   = bcta_pkg::BCTA_BLOCKS_DEF,
   parameter int RESERVED = bcta_pkg::BCTA_RESERVED_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [10:0] block, [21:11] other_block, [23:22] zero
   input  wire logic [2:0]  req_tuser,   // [2:0] kind
   // Response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [2:0] status, [13:3] result_block, [15:14] zero
   output logic             rsp_tuser    // chain_end
);

   import bcta_pkg::*;

   localparam int IW = $clog2(BLOCKS);
   localparam int CW = IW + 2;
   localparam int EW = $clog2(BLOCKS + 6);

   // Table memory port
   logic          ram_we;
   logic [IW-1:0] ram_waddr;
   logic [EW-1:0] ram_wdata;
   logic [IW-1:0] ram_raddr;
   logic [EW-1:0] ram_rdata;

   // Candidate walker for the allocate scans
   bcta_scan_ctl_type scan_ctl;
   logic [CW-1:0]     scan_hint;
   logic              scan_emit;
   logic [IW-1:0]     scan_addr;

   bcta_ram #(
      .WIDTH (EW),
      .DEPTH (BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Walk the hint outward, lower side first, or upward only for allocate first
   bcta_scan #(
      .BLOCKS (BLOCKS)
   ) u_scan (
      .clock     (clock),
      .scan_ctl  (scan_ctl),
      .scan_hint (scan_hint),
      .scan_emit (scan_emit),
      .scan_addr (scan_addr)
   );

   // Sequence each transaction: read, check, write back where needed, then hold the result
   bcta_ctrl #(
      .BLOCKS   (BLOCKS),
      .RESERVED (RESERVED)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata),
      .scan_ctl   (scan_ctl),
      .scan_hint  (scan_hint),
      .scan_emit  (scan_emit),
      .scan_addr  (scan_addr)
   );

   // One transaction at a time: drop ready right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while a transaction is in flight");

   // Table writes belong to a transaction or the clearing pass, never to idle
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> !req_tready)
      else $error("table write while idle");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= ST_ALREADY)
      else $error("undefined status code");

   a_end_is_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[2:0] == ST_OK)
      else $error("chain end reported with a failing status");

endmodule

`default_nettype wire
